@@ rtl/core/ute_pkg.sv @@
// Shared types and constants for the serial transmitter and receiver engine.
// Holds register reset values, frame phases, sequencer states and the
// command and status structs used between the controller and the datapath.
`timescale 1ns / 1ps

package ute_pkg;

    localparam int TX_QUEUE_DEPTH = 16;

    localparam int PERIOD_W  = 24;
    localparam int TIMER_W   = 28;
    localparam int ELAPSED_W = 16;
    localparam int DBITS_W   = 4;
    localparam int SBITS_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 24'd872727;
    localparam logic [DBITS_W-1:0]  DATA_BITS_RST  = 4'd8;
    localparam logic [SBITS_W-1:0]  STOP_BITS_RST  = 2'd1;
    localparam logic [DBITS_W-1:0]  DATA_BITS_MAX  = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_PERIOD = 2'd0,
        CFG_DATA_BITS  = 2'd1,
        CFG_STOP_BITS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PUSH    = 3'd1,
        ST_RX_SUB  = 3'd2,
        ST_RX_LOOP = 3'd3,
        ST_TX_SUB  = 3'd4,
        ST_TX_LOOP = 3'd5,
        ST_DONE    = 3'd6
    } t_state;

    typedef struct packed {
        logic latch;
        logic push;
        logic rx_sub;
        logic rx_step;
        logic tx_sub;
        logic tx_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic   elapsed_zero;
        t_phase rx_phase;
        logic   rx_expired;
        logic   rx_last;
        t_phase tx_phase;
        logic   tx_expired;
        logic   tx_last;
    } t_stat;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_fifo_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

@@ rtl/core/ute_ifs.sv @@
// Valid/ready channel interfaces for items, results and register writes.
// Depends on ute_pkg for field widths.
`timescale 1ns / 1ps

interface ute_item_if;
    logic                               valid;
    logic                               ready;
    logic [ute_pkg::ELAPSED_W-1:0]      elapsed_cycles;
    logic                               rx_level;
    logic                               tx_push;
    logic [ute_pkg::BYTE_W-1:0]         tx_byte;

    modport source (output valid, elapsed_cycles, rx_level, tx_push, tx_byte, input ready);
    modport sink (input valid, elapsed_cycles, rx_level, tx_push, tx_byte, output ready);
endinterface

interface ute_result_if;
    logic                               valid;
    logic                               ready;
    logic                               tx_level;
    logic                               rx_valid;
    logic [ute_pkg::BYTE_W-1:0]         rx_byte;
    logic                               tx_idle;
    logic                               tx_full;

    modport source (output valid, tx_level, rx_valid, rx_byte, tx_idle, tx_full, input ready);
    modport sink (input valid, tx_level, rx_valid, rx_byte, tx_idle, tx_full, output ready);
endinterface

interface ute_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ute_pkg::CFG_IDX_W-1:0]      index;
    logic [ute_pkg::PERIOD_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/ute_fifo.sv @@
// Transmit byte queue: a single-port-write, registered-read memory with
// wrapping pointers and an occupancy count. Depends on ute_pkg.
`timescale 1ns / 1ps

module ute_fifo #(
    parameter int DEPTH = ute_pkg::TX_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ute_pkg::t_fifo_req          i_req,
    input  logic [ute_pkg::BYTE_W-1:0]  i_wdata,
    output logic [ute_pkg::BYTE_W-1:0]  o_rdata,
    output ute_pkg::t_fifo_stat         o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [ute_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [ute_pkg::BYTE_W-1:0] r_rdata;
    logic [AW-1:0]              r_wptr, n_wptr;
    logic [AW-1:0]              r_rptr, n_rptr;
    logic [CW-1:0]              r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_req.wr) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_req.rd) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_req.wr && !i_req.rd) begin
            n_count = r_count + 1'b1;
        end else if (i_req.rd && !i_req.wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
        r_rdata <= r_mem[r_rptr];
    end

    assign o_rdata    = r_rdata;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_COUNT);

endmodule

@@ rtl/core/ute_ctrl.sv @@
// Item sequencer: steps push, receive and transmit phases one bit boundary
// per cycle and owns the result valid flag. Depends on ute_pkg.
`timescale 1ns / 1ps

module ute_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ute_pkg::t_stat  i_stat,
    output ute_pkg::t_cmd   o_cmd
);

    ute_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ute_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ute_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ute_pkg::ST_PUSH;
                end
            end
            ute_pkg::ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_stat.elapsed_zero ? ute_pkg::ST_DONE : ute_pkg::ST_RX_SUB;
            end
            ute_pkg::ST_RX_SUB: begin
                o_cmd.rx_sub = 1'b1;
                n_state = (i_stat.rx_phase == ute_pkg::PH_IDLE) ? ute_pkg::ST_TX_SUB
                                                                 : ute_pkg::ST_RX_LOOP;
            end
            ute_pkg::ST_RX_LOOP: begin
                n_state = ute_pkg::ST_TX_SUB;
                if (i_stat.rx_expired) begin
                    o_cmd.rx_step = 1'b1;
                    if (i_stat.rx_phase == ute_pkg::PH_DATA && !i_stat.rx_last) begin
                        n_state = ute_pkg::ST_RX_LOOP;
                    end
                end
            end
            ute_pkg::ST_TX_SUB: begin
                o_cmd.tx_sub = 1'b1;
                n_state = (i_stat.tx_phase == ute_pkg::PH_IDLE) ? ute_pkg::ST_DONE
                                                                 : ute_pkg::ST_TX_LOOP;
            end
            ute_pkg::ST_TX_LOOP: begin
                n_state = ute_pkg::ST_DONE;
                if (i_stat.tx_expired) begin
                    o_cmd.tx_step = 1'b1;
                    if (i_stat.tx_phase == ute_pkg::PH_DATA && !i_stat.tx_last) begin
                        n_state = ute_pkg::ST_TX_LOOP;
                    end
                end
            end
            ute_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ute_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ute_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ute_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/ute_dp.sv @@
// Datapath: configuration registers, receive and transmit timers, shift
// registers, bit counters and the result register. Depends on ute_pkg.
`timescale 1ns / 1ps

module ute_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ute_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ute_pkg::PERIOD_W-1:0]    i_cfg_data,
    input  logic [ute_pkg::ELAPSED_W-1:0]   i_elapsed_cycles,
    input  logic                            i_rx_level,
    input  logic                            i_tx_push,
    input  logic [ute_pkg::BYTE_W-1:0]      i_tx_byte,
    input  ute_pkg::t_cmd                   i_cmd,
    output ute_pkg::t_stat                  o_stat,
    output ute_pkg::t_fifo_req              o_fifo_req,
    output logic [ute_pkg::BYTE_W-1:0]      o_fifo_wdata,
    input  logic [ute_pkg::BYTE_W-1:0]      i_fifo_rdata,
    input  ute_pkg::t_fifo_stat             i_fifo_stat,
    output logic                            o_tx_level,
    output logic                            o_rx_valid,
    output logic [ute_pkg::BYTE_W-1:0]      o_rx_byte,
    output logic                            o_tx_idle,
    output logic                            o_tx_full
);

    localparam int TW = ute_pkg::TIMER_W;
    localparam int PW = ute_pkg::PERIOD_W;

    logic [PW-1:0]                      r_bit_period;
    logic [ute_pkg::DBITS_W-1:0]        r_data_bits;
    logic [ute_pkg::SBITS_W-1:0]        r_stop_bits;

    logic [ute_pkg::ELAPSED_W-1:0]      r_elapsed;
    logic                               r_level;
    logic                               r_push;
    logic [ute_pkg::BYTE_W-1:0]         r_byte;
    logic                               r_full;
    logic                               r_rx_done;
    logic [ute_pkg::BYTE_W-1:0]         r_rx_data;

    ute_pkg::t_phase                    r_rx_phase;
    logic signed [TW-1:0]               r_rx_timer;
    logic [ute_pkg::BYTE_W-1:0]         r_rx_shift;
    logic [ute_pkg::CNT_W-1:0]          r_rx_count;
    logic                               r_prev_level;

    ute_pkg::t_phase                    r_tx_phase;
    logic signed [TW-1:0]               r_tx_timer;
    logic [ute_pkg::BYTE_W-1:0]         r_tx_shift;
    logic [ute_pkg::CNT_W-1:0]          r_tx_count;
    logic                               r_tx_line;

    logic                               r_o_tx_level;
    logic                               r_o_rx_valid;
    logic [ute_pkg::BYTE_W-1:0]         r_o_rx_byte;
    logic                               r_o_tx_idle;
    logic                               r_o_tx_full;

    logic [ute_pkg::DBITS_W-1:0]        w_db;
    logic [ute_pkg::SBITS_W-1:0]        w_sb;
    logic signed [TW-1:0]               w_dec;
    logic signed [TW-1:0]               w_per;
    logic [PW+1:0]                      w_per3;
    logic signed [TW-1:0]               w_rx_start;
    logic signed [TW-1:0]               w_stop_len;
    logic [ute_pkg::CNT_W-1:0]          w_rx_count_inc;

    always_comb begin
        w_db = r_data_bits;
        if (r_data_bits == '0 || r_data_bits > ute_pkg::DATA_BITS_MAX) begin
            w_db = ute_pkg::DATA_BITS_MAX;
        end
        w_sb = (r_stop_bits == '0) ? 2'd1 : r_stop_bits;
        w_dec      = $signed({4'b0, r_elapsed, 8'b0});
        w_per      = $signed({4'b0, r_bit_period});
        w_per3     = {2'b0, r_bit_period} + {1'b0, r_bit_period, 1'b0};
        w_rx_start = $signed({3'b0, w_per3[PW+1:1]});
        case (w_sb)
            2'd2:    w_stop_len = $signed({3'b0, r_bit_period, 1'b0});
            2'd3:    w_stop_len = $signed({2'b0, w_per3});
            default: w_stop_len = w_per;
        endcase
        w_rx_count_inc = r_rx_count + 1'b1;
    end

    assign o_stat.elapsed_zero = (r_elapsed == '0);
    assign o_stat.rx_phase     = r_rx_phase;
    assign o_stat.rx_expired   = r_rx_timer[TW-1] || (r_rx_timer == '0);
    assign o_stat.rx_last      = (w_rx_count_inc >= w_db);
    assign o_stat.tx_phase     = r_tx_phase;
    assign o_stat.tx_expired   = r_tx_timer[TW-1] || (r_tx_timer == '0);
    assign o_stat.tx_last      = (r_tx_count >= w_db);

    assign o_fifo_req.wr = i_cmd.push && r_push && !i_fifo_stat.full;
    assign o_fifo_req.rd = i_cmd.tx_sub && (r_tx_phase == ute_pkg::PH_IDLE)
                           && !i_fifo_stat.empty;
    assign o_fifo_wdata  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= ute_pkg::BIT_PERIOD_RST;
            r_data_bits  <= ute_pkg::DATA_BITS_RST;
            r_stop_bits  <= ute_pkg::STOP_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ute_pkg::CFG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                ute_pkg::CFG_DATA_BITS:  r_data_bits  <= i_cfg_data[ute_pkg::DBITS_W-1:0];
                ute_pkg::CFG_STOP_BITS:  r_stop_bits  <= i_cfg_data[ute_pkg::SBITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_elapsed <= i_elapsed_cycles;
            r_level   <= i_rx_level;
            r_push    <= i_tx_push;
            r_byte    <= i_tx_byte;
        end
        if (i_cmd.load_out) begin
            r_o_tx_level <= r_tx_line;
            r_o_rx_valid <= r_rx_done;
            r_o_rx_byte  <= r_rx_data;
            r_o_tx_idle  <= (r_tx_phase == ute_pkg::PH_IDLE) && i_fifo_stat.empty;
            r_o_tx_full  <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full       <= 1'b0;
            r_rx_done    <= 1'b0;
            r_rx_data    <= '0;
            r_rx_phase   <= ute_pkg::PH_IDLE;
            r_rx_timer   <= '0;
            r_rx_shift   <= '0;
            r_rx_count   <= '0;
            r_prev_level <= 1'b1;
            r_tx_phase   <= ute_pkg::PH_IDLE;
            r_tx_timer   <= '0;
            r_tx_shift   <= '0;
            r_tx_count   <= '0;
            r_tx_line    <= 1'b1;
        end else begin
            if (i_cmd.latch) begin
                r_full    <= 1'b0;
                r_rx_done <= 1'b0;
                r_rx_data <= '0;
            end
            if (i_cmd.push) begin
                r_full <= r_push && i_fifo_stat.full;
            end

            if (i_cmd.rx_sub) begin
                r_prev_level <= r_level;
                if (r_rx_phase == ute_pkg::PH_IDLE) begin
                    if (r_prev_level && !r_level) begin
                        r_rx_phase <= ute_pkg::PH_DATA;
                        r_rx_timer <= w_rx_start;
                        r_rx_shift <= '0;
                        r_rx_count <= '0;
                    end
                end else begin
                    r_rx_timer <= r_rx_timer - w_dec;
                end
            end
            if (i_cmd.rx_step) begin
                if (r_rx_phase == ute_pkg::PH_DATA) begin
                    if (r_level) begin
                        r_rx_shift <= r_rx_shift | (8'h01 << r_rx_count[2:0]);
                    end
                    r_rx_count <= w_rx_count_inc;
                    if (w_rx_count_inc >= w_db) begin
                        r_rx_phase <= ute_pkg::PH_STOP;
                    end
                    r_rx_timer <= r_rx_timer + w_per;
                end else begin
                    if (r_level) begin
                        r_rx_done <= 1'b1;
                        r_rx_data <= r_rx_shift;
                    end
                    r_rx_phase <= ute_pkg::PH_IDLE;
                    r_rx_timer <= '0;
                    r_rx_count <= '0;
                    r_rx_shift <= '0;
                end
            end

            if (i_cmd.tx_sub) begin
                if (r_tx_phase == ute_pkg::PH_IDLE) begin
                    r_tx_line <= i_fifo_stat.empty;
                    if (!i_fifo_stat.empty) begin
                        r_tx_shift <= i_fifo_rdata;
                        r_tx_count <= '0;
                        r_tx_timer <= w_per;
                        r_tx_phase <= ute_pkg::PH_START;
                    end
                end else begin
                    r_tx_timer <= r_tx_timer - w_dec;
                end
            end
            if (i_cmd.tx_step) begin
                case (r_tx_phase)
                    ute_pkg::PH_START: begin
                        r_tx_line  <= r_tx_shift[0];
                        r_tx_shift <= r_tx_shift >> 1;
                        r_tx_count <= 4'd1;
                        r_tx_timer <= r_tx_timer + w_per;
                        r_tx_phase <= ute_pkg::PH_DATA;
                    end
                    ute_pkg::PH_DATA: begin
                        if (r_tx_count >= w_db) begin
                            r_tx_line  <= 1'b1;
                            r_tx_timer <= r_tx_timer + w_stop_len;
                            r_tx_phase <= ute_pkg::PH_STOP;
                        end else begin
                            r_tx_line  <= r_tx_shift[0];
                            r_tx_shift <= r_tx_shift >> 1;
                            r_tx_count <= r_tx_count + 1'b1;
                            r_tx_timer <= r_tx_timer + w_per;
                        end
                    end
                    ute_pkg::PH_STOP: begin
                        r_tx_line  <= 1'b1;
                        r_tx_phase <= ute_pkg::PH_IDLE;
                        r_tx_timer <= '0;
                        r_tx_count <= '0;
                        r_tx_shift <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_tx_level = r_o_tx_level;
    assign o_rx_valid = r_o_rx_valid;
    assign o_rx_byte  = r_o_rx_byte;
    assign o_tx_idle  = r_o_tx_idle;
    assign o_tx_full  = r_o_tx_full;

endmodule

@@ rtl/core/uart_tx_rx_engine.sv @@
// Serial transmitter and receiver engine, top level.
// Items arrive on i_item: each may queue tx_byte for transmission and then
// advances time by elapsed_cycles clock cycles with the receive line at
// rx_level. Each item produces exactly one result on o_result carrying the
// transmit line level, a received character with its valid flag, the
// transmitter idle flag and a queue-full flag for a dropped push.
// Registers bit_period (16.8 fixed point), data_bits and stop_bits are
// written through i_cfg, which is always ready; write them only while no
// item is in flight.
// An item is latched in idle, may push its byte, and goes straight to
// done when elapsed_cycles is zero; otherwise the receiver, then the
// transmitter, each pass a subtract state and, mid-frame, a loop state
// taking one step per expired bit boundary, up to eight each. The next
// item is accepted the cycle after a result enters the output register.
// Reset clears all timers, phases and the queue count and restores the
// register defaults; queue contents are not cleared. When the result
// consumer stalls, one finished result waits in the output register and
// the next item is processed up to its result, then holds.
`timescale 1ns / 1ps

module uart_tx_rx_engine #(
    parameter int TX_QUEUE_DEPTH = ute_pkg::TX_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ute_item_if.sink        i_item,
    ute_result_if.source    o_result,
    ute_cfg_if.sink         i_cfg
);

    ute_pkg::t_cmd                  w_cmd;
    ute_pkg::t_stat                 w_stat;
    ute_pkg::t_fifo_req             w_fifo_req;
    ute_pkg::t_fifo_stat            w_fifo_stat;
    logic [ute_pkg::BYTE_W-1:0]     w_fifo_wdata;
    logic [ute_pkg::BYTE_W-1:0]     w_fifo_rdata;

    assign i_cfg.ready = 1'b1;

    ute_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ute_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_elapsed_cycles (i_item.elapsed_cycles),
        .i_rx_level       (i_item.rx_level),
        .i_tx_push        (i_item.tx_push),
        .i_tx_byte        (i_item.tx_byte),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_fifo_req       (w_fifo_req),
        .o_fifo_wdata     (w_fifo_wdata),
        .i_fifo_rdata     (w_fifo_rdata),
        .i_fifo_stat      (w_fifo_stat),
        .o_tx_level       (o_result.tx_level),
        .o_rx_valid       (o_result.rx_valid),
        .o_rx_byte        (o_result.rx_byte),
        .o_tx_idle        (o_result.tx_idle),
        .o_tx_full        (o_result.tx_full)
    );

    ute_fifo #(
        .DEPTH (TX_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_fifo_req),
        .i_wdata (w_fifo_wdata),
        .o_rdata (w_fifo_rdata),
        .o_stat  (w_fifo_stat)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_req.wr |-> !w_fifo_stat.full)
        else $error("transmit queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_req.rd |-> !w_fifo_stat.empty)
        else $error("transmit queue read while empty");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item accepted while another is in progress");

    a_byte_zero_without_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.rx_valid) |-> (o_result.rx_byte == '0))
        else $error("received byte nonzero without valid flag");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for uart_tx_rx_engine: directed rows, then random serial frames and
// transmit queue traffic under several register settings, checked against a local line model.
// Depends on ute_pkg, the ute_*_if interfaces and the engine RTL.
module tb;
    import ute_pkg::*;

    localparam int CYCLE_LIMIT       = 600000;
    localparam int DIR_ROWS          = 25;
    localparam int N_SETTINGS        = 7;
    localparam int ITEMS_PER_SETTING = 132;
    localparam int TOTAL_ITEMS       = DIR_ROWS + N_SETTINGS * ITEMS_PER_SETTING;
    localparam int SETTLE_CYCLES     = 30;
    localparam int PUSH_BLOCK        = 44;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 level;
        logic                 push;
        logic [BYTE_W-1:0]    data;
    } t_uart_item;

    typedef struct packed {
        logic              tx_level;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_idle;
        logic              tx_full;
    } t_uart_result;

    typedef struct packed {
        t_uart_item   item;
        logic         has_fixed;
        t_uart_result res;
    } t_dir_row;

    typedef struct packed {
        logic level;
        logic fresh;
        int   left;
    } t_line_seg;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [DBITS_W-1:0]  dbits;
        logic [SBITS_W-1:0]  sbits;
    } t_setting;

    localparam t_uart_result RES_NONE      = '0;
    localparam t_uart_result RES_IDLE      = '{1'b1, 1'b0, 8'h00, 1'b1, 1'b0};
    localparam t_uart_result RES_QUEUED    = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam t_uart_result RES_START_BIT = '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0};

    logic i_clk;
    logic i_rst_n;

    ute_item_if   item_if();
    ute_result_if result_if();
    ute_cfg_if    cfg_if();

    uart_tx_rx_engine u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    logic [PERIOD_W-1:0] reg_period;
    logic [DBITS_W-1:0]  reg_dbits;
    logic [SBITS_W-1:0]  reg_sbits;

    t_phase            rcv_phase;
    int                rcv_timer;
    logic [BYTE_W-1:0] rcv_shift;
    int                rcv_count;
    logic              rcv_prev_level;

    t_phase            xmt_phase;
    int                xmt_timer;
    logic [BYTE_W-1:0] xmt_shift;
    int                xmt_count;
    logic              xmt_line;
    logic [BYTE_W-1:0] xmt_fifo[$];

    t_uart_result uart_outcomes[$];
    t_line_seg    line_segs[$];

    logic         item_has_fixed;
    t_uart_result item_fixed_res;

    int src_idle_pct;
    int snk_stall_pct;
    int push_pct;
    int n_sent;
    int n_checked;
    int n_rx_chars;
    int n_drops;
    int n_errors;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_data_bits();
        if (reg_dbits == '0 || reg_dbits > DATA_BITS_MAX) begin
            return int'(DATA_BITS_MAX);
        end
        return int'(reg_dbits);
    endfunction

    function automatic t_uart_result advance_uart(input t_uart_item it);
        t_uart_result r;
        int           dec;
        int           per;
        int           nbits;
        int           nstop;
        r = RES_NONE;
        per = int'(reg_period);
        nbits = eff_data_bits();
        nstop = (reg_sbits == '0) ? 1 : int'(reg_sbits);
        if (it.push) begin
            if (xmt_fifo.size() >= TX_QUEUE_DEPTH) begin
                r.tx_full = 1'b1;
            end else begin
                xmt_fifo.push_back(it.data);
            end
        end
        if (it.elapsed != '0) begin
            dec = int'(it.elapsed) * 256;
            // The receiver is stepped before the transmitter.
            if (rcv_phase == PH_IDLE) begin
                if (rcv_prev_level && !it.level) begin
                    rcv_phase = PH_DATA;
                    rcv_timer = (per * 3) >> 1;
                    rcv_shift = '0;
                    rcv_count = 0;
                end
            end else if (rcv_phase == PH_DATA) begin
                rcv_timer -= dec;
                while (rcv_timer <= 0 && rcv_phase == PH_DATA) begin
                    if (it.level) begin
                        rcv_shift[rcv_count % 8] = 1'b1;
                    end
                    rcv_count++;
                    if (rcv_count >= nbits) begin
                        rcv_phase = PH_STOP;
                    end
                    rcv_timer += per;
                end
            end else begin
                rcv_timer -= dec;
                if (rcv_timer <= 0) begin
                    if (it.level) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = rcv_shift;
                    end
                    rcv_phase = PH_IDLE;
                    rcv_timer = 0;
                    rcv_count = 0;
                    rcv_shift = '0;
                end
            end
            rcv_prev_level = it.level;

            if (xmt_phase == PH_IDLE) begin
                xmt_line = 1'b1;
                if (xmt_fifo.size() != 0) begin
                    xmt_shift = xmt_fifo.pop_front();
                    xmt_count = 0;
                    xmt_timer = per;
                    xmt_line = 1'b0;
                    xmt_phase = PH_START;
                end
            end else if (xmt_phase == PH_START) begin
                xmt_timer -= dec;
                if (xmt_timer <= 0) begin
                    xmt_line = xmt_shift[0];
                    xmt_shift = xmt_shift >> 1;
                    xmt_count = 1;
                    xmt_timer += per;
                    xmt_phase = PH_DATA;
                end
            end else if (xmt_phase == PH_DATA) begin
                xmt_timer -= dec;
                while (xmt_timer <= 0 && xmt_phase == PH_DATA) begin
                    if (xmt_count >= nbits) begin
                        xmt_line = 1'b1;
                        xmt_timer += per * nstop;
                        xmt_phase = PH_STOP;
                    end else begin
                        xmt_line = xmt_shift[0];
                        xmt_shift = xmt_shift >> 1;
                        xmt_count++;
                        xmt_timer += per;
                    end
                end
            end else begin
                xmt_timer -= dec;
                if (xmt_timer <= 0) begin
                    xmt_line = 1'b1;
                    xmt_phase = PH_IDLE;
                    xmt_timer = 0;
                    xmt_count = 0;
                    xmt_shift = '0;
                end
            end
        end
        r.tx_level = xmt_line;
        r.tx_idle = (xmt_phase == PH_IDLE) && (xmt_fifo.size() == 0);
        return r;
    endfunction

    function automatic t_dir_row dir_row(input int i);
        case (i)
            0:  return '{'{16'd0,     1'b1, 1'b0, 8'h00}, 1'b1, RES_IDLE};
            1:  return '{'{16'd1,     1'b1, 1'b0, 8'h00}, 1'b1, RES_IDLE};
            2:  return '{'{16'd0,     1'b1, 1'b1, 8'hFF}, 1'b1, RES_QUEUED};
            3:  return '{'{16'd0,     1'b1, 1'b1, 8'h00}, 1'b1, RES_QUEUED};
            4:  return '{'{16'd1,     1'b1, 1'b0, 8'h00}, 1'b1, RES_START_BIT};
            5:  return '{'{16'd65535, 1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            6:  return '{'{16'd65535, 1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            7:  return '{'{16'd65535, 1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            8:  return '{'{16'd100,   1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            9:  return '{'{16'd5114,  1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            10: return '{'{16'd3410,  1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            11: return '{'{16'd3410,  1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            12: return '{'{16'd3410,  1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            13: return '{'{16'd3410,  1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            14: return '{'{16'd3410,  1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            15: return '{'{16'd3410,  1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            16: return '{'{16'd3410,  1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            17: return '{'{16'd3410,  1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            18: return '{'{16'd65535, 1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            19: return '{'{16'd65535, 1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            20: return '{'{16'd65535, 1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            21: return '{'{16'd65535, 1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            22: return '{'{16'd65535, 1'b0, 1'b0, 8'h00}, 1'b0, RES_NONE};
            23: return '{'{16'd65535, 1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
            default: return '{'{16'd65535, 1'b1, 1'b0, 8'h00}, 1'b0, RES_NONE};
        endcase
    endfunction

    function automatic t_setting setting_at(input int i);
        case (i)
            0: return '{24'd256,      4'd8,  2'd1};
            1: return '{24'hFFFFFF,   4'd1,  2'd3};
            2: return '{24'd2560,     4'd5,  2'd2};
            3: return '{24'd0,        4'd0,  2'd0};
            4: return '{24'd100,      4'd12, 2'd3};
            5: return '{24'd872727,   4'd7,  2'd2};
            default: return '{24'd1280, 4'd15, 2'd1};
        endcase
    endfunction

    // One serial character: start bit, data bits, stop bit and some idle line after it.
    // A few frames carry a wrong length or a low stop bit.
    function automatic void queue_frame(input int bit_cyc);
        int nbits;
        nbits = ($urandom_range(99, 0) < 85) ? eff_data_bits() : int'($urandom_range(9, 1));
        line_segs.push_back('{1'b0, 1'b1, bit_cyc});
        for (int i = 0; i < nbits; i++) begin
            line_segs.push_back('{1'($urandom), 1'b0, bit_cyc});
        end
        line_segs.push_back('{($urandom_range(99, 0) >= 12), 1'b0, bit_cyc});
        line_segs.push_back('{1'b1, 1'b0, bit_cyc * int'($urandom_range(3, 1))});
    endfunction

    function automatic t_uart_item next_random_item();
        t_uart_item it;
        t_line_seg  seg;
        int         bit_cyc;
        int         e;
        int         roll;
        it.push = ($urandom_range(99, 0) < push_pct);
        it.data = 8'($urandom);
        roll = $urandom_range(99, 0);
        if (roll < 5) begin
            it.elapsed = '0;
            it.level = 1'($urandom);
        end else if (roll < 14) begin
            it.elapsed = 16'($urandom_range(65535, 1));
            it.level = 1'($urandom);
        end else begin
            bit_cyc = (int'(reg_period) + 255) / 256;
            if (bit_cyc < 1) begin
                bit_cyc = 1;
            end
            if (line_segs.size() == 0) begin
                queue_frame(bit_cyc);
            end
            seg = line_segs.pop_front();
            if (seg.fresh) begin
                e = 1;
            end else if ($urandom_range(1, 0) == 0) begin
                e = seg.left;
            end else begin
                e = int'($urandom_range(seg.left, 1));
            end
            if (e > 65535) begin
                e = 65535;
            end
            it.elapsed = 16'(e);
            it.level = seg.level;
            seg.fresh = 1'b0;
            seg.left -= e;
            if (seg.left > 0) begin
                line_segs.push_front(seg);
            end
        end
        return it;
    endfunction

    task automatic set_pace(input int n);
        if (n < TOTAL_ITEMS / 3) begin
            src_idle_pct = 26;
            snk_stall_pct = 80;
        end else if (n < 2 * TOTAL_ITEMS / 3) begin
            src_idle_pct = 80;
            snk_stall_pct = 26;
        end else begin
            src_idle_pct = 0;
            snk_stall_pct = 0;
        end
    endtask

    task automatic send_item(input t_uart_item it, input logic fix, input t_uart_result res);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.elapsed_cycles <= it.elapsed;
        item_if.rx_level <= it.level;
        item_if.tx_push <= it.push;
        item_if.tx_byte <= it.data;
        item_has_fixed <= fix;
        item_fixed_res <= res;
        do @(posedge i_clk); while (!item_if.ready);
        n_sent++;
    endtask

    task automatic drain_results(input int extra);
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (uart_outcomes.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Upper bits of the narrow registers are filled with noise; only the low bits count.
    task automatic apply_setting(input t_setting st, input logic spare);
        logic [PERIOD_W-1:0] word;
        write_reg(CFG_BIT_PERIOD, st.period);
        word = PERIOD_W'($urandom);
        word[DBITS_W-1:0] = st.dbits;
        write_reg(CFG_DATA_BITS, word);
        word = PERIOD_W'($urandom);
        word[SBITS_W-1:0] = st.sbits;
        write_reg(CFG_STOP_BITS, word);
        if (spare) begin
            write_reg(CFG_SPARE, PERIOD_W'($urandom));
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input t_uart_result want,
                                   input t_uart_result got);
        n_errors++;
        $display("%0t: %s: expected tx=%0b rxv=%0b rxb=%02h idle=%0b full=%0b,",
                 $time, what, want.tx_level, want.rx_valid, want.rx_byte, want.tx_idle,
                 want.tx_full);
        $display("    actual tx=%0b rxv=%0b rxb=%02h idle=%0b full=%0b",
                 got.tx_level, got.rx_valid, got.rx_byte, got.tx_idle, got.tx_full);
    endtask

    always @(negedge i_clk) begin
        result_if.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_uart_item   it;
        t_uart_result want;
        t_uart_result got;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_BIT_PERIOD: reg_period = cfg_if.data;
                    CFG_DATA_BITS:  reg_dbits = cfg_if.data[DBITS_W-1:0];
                    CFG_STOP_BITS:  reg_sbits = cfg_if.data[SBITS_W-1:0];
                    default: ;
                endcase
            end
            if (item_if.valid && item_if.ready) begin
                it = '{item_if.elapsed_cycles, item_if.rx_level, item_if.tx_push,
                       item_if.tx_byte};
                want = advance_uart(it);
                if (item_has_fixed) begin
                    want = item_fixed_res;
                end
                uart_outcomes.push_back(want);
            end
            if (result_if.valid && result_if.ready) begin
                got = '{result_if.tx_level, result_if.rx_valid, result_if.rx_byte,
                        result_if.tx_idle, result_if.tx_full};
                if (uart_outcomes.size() == 0) begin
                    report_mismatch("unexpected transfer", RES_NONE, got);
                end else begin
                    want = uart_outcomes.pop_front();
                    n_checked++;
                    n_rx_chars += want.rx_valid;
                    n_drops += want.tx_full;
                    if (got.tx_level !== want.tx_level || got.rx_valid !== want.rx_valid ||
                        got.rx_byte !== want.rx_byte || got.tx_idle !== want.tx_idle ||
                        got.tx_full !== want.tx_full) begin
                        report_mismatch("result mismatch", want, got);
                    end
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        t_dir_row row;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.elapsed_cycles = '0;
        item_if.rx_level = 1'b1;
        item_if.tx_push = 1'b0;
        item_if.tx_byte = '0;
        result_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_BIT_PERIOD;
        cfg_if.data = '0;
        item_has_fixed = 1'b0;
        item_fixed_res = RES_NONE;
        reg_period = BIT_PERIOD_RST;
        reg_dbits = DATA_BITS_RST;
        reg_sbits = STOP_BITS_RST;
        rcv_phase = PH_IDLE;
        rcv_timer = 0;
        rcv_shift = '0;
        rcv_count = 0;
        rcv_prev_level = 1'b1;
        xmt_phase = PH_IDLE;
        xmt_timer = 0;
        xmt_shift = '0;
        xmt_count = 0;
        xmt_line = 1'b1;
        push_pct = 30;
        n_sent = 0;
        n_checked = 0;
        n_rx_chars = 0;
        n_drops = 0;
        n_errors = 0;
        set_pace(0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_row(i);
            set_pace(n_sent);
            send_item(row.item, row.has_fixed, row.res);
        end

        for (int s = 0; s < N_SETTINGS; s++) begin
            drain_results(SETTLE_CYCLES);
            apply_setting(setting_at(s), s == 3);
            for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                if (k % PUSH_BLOCK == 0) begin
                    case ($urandom_range(2, 0))
                        0: push_pct = 4;
                        1: push_pct = 25;
                        default: push_pct = 100;
                    endcase
                end
                set_pace(n_sent);
                send_item(next_random_item(), 1'b0, RES_NONE);
            end
        end

        drain_results(SETTLE_CYCLES);
        $display("Sent %0d items over %0d register settings; %0d results checked.",
                 n_sent, N_SETTINGS + 1, n_checked);
        $display("Characters received: %0d, pushes dropped on a full queue: %0d.",
                 n_rx_chars, n_drops);
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ute_pkg.sv
rtl/core/ute_ifs.sv
rtl/core/ute_fifo.sv
rtl/core/ute_ctrl.sv
rtl/core/ute_dp.sv
rtl/core/uart_tx_rx_engine.sv
sim/tb.sv
